// ===== design/rat_pkg.sv =====
// Package for the rational add/multiply/reduce block.
// Holds widths, range limits, operation codes and the divider request/reply structs.
package rat_pkg;
  localparam int W  = 32;
  localparam int DW = 2 * W;
  localparam int CW = $clog2(DW + 1);

  // largest magnitude of a positive / negative reduced field
  localparam logic [DW-1:0] POS_MAX = (DW'(1) << (W - 1)) - DW'(1);
  localparam logic [DW-1:0] NEG_MAG = DW'(1) << (W - 1);

  typedef enum logic [1:0] {
    FUNC_RED = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_BAD = 2'd3
  } func_t;

  typedef struct packed {
    logic          go;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } div_rsp_t;
endpackage

// ===== design/rational_add_mul_reduce_top.sv =====
// Rational add / multiply / reduce, top level.
// Depends on rat_pkg and rat_div.
//
// Pulse start while busy is low to issue a request (func, a_num/a_den,
// b_num/b_den). busy is high from the cycle after acceptance until the
// single result appears on res_* with done high for exactly one cycle; there
// is no back-pressure, so capture it then. A zero denominator or func = 3
// answers from the PREP state without a divide. Every other request runs
// through one shift-subtract divider and one 32x32 multiplier. Euclid needs
// up to about 47 steps on 32-bit magnitudes and about 93 on 64-bit
// products and sums. Results are in lowest terms with positive denominator;
// zero is 0/1. zero_den_error flags a zero denominator in use, overflow a
// reduced result outside 32-bit range; either way the value is 0/1.
// func = 3 returns 0/1 with no flags.
module rational_add_mul_reduce_top
  import rat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic signed [W-1:0] a_num,
  input  logic signed [W-1:0] a_den,
  input  logic signed [W-1:0] b_num,
  input  logic signed [W-1:0] b_den,
  output logic                done,
  output logic signed [W-1:0] res_num,
  output logic [W-2:0]        res_den,
  output logic                zero_den_error,
  output logic                overflow
);
  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_MULD, S_GCD, S_GCDW, S_LA, S_LAW, S_LB, S_LBW,
    S_ML, S_MA, S_MB, S_SUM, S_DIVN, S_DIVNW, S_DIVD, S_DIVDW, S_CHK
  } state_t;

  state_t        state;
  func_t         op;
  div_req_t      dreq;
  div_rsp_t      drsp;
  // operand magnitudes and the two cofactors ad/g, bd/g of the lcm
  logic [W-1:0]  an, ad, bn, bd, qa, qb;
  logic [DW-1:0] x, y, num, den, g, ta, tb;
  logic          sa, sb, neg;
  logic          lcm_pass;   // first Euclid run of an add: gcd of denominators
  logic          bad_den, go_next, done_next;
  logic [DW-1:0] sum_val;
  logic          sum_neg;

  rat_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // magnitude of a two's complement field; the most negative value keeps 2^(W-1)
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  // the one multiplier: a single 32x32 product per cycle
  logic [W-1:0]  m_a, m_b;
  logic [DW-1:0] m_p;
  assign m_p = DW'(m_a) * DW'(m_b);

  always_comb begin
    unique case (state)
      S_MULD:  begin m_a = ad; m_b = bd; end
      S_ML:    begin m_a = qa; m_b = bd; end   // lcm = (ad/g) * bd
      S_MA:    begin m_a = an; m_b = qb; end   // an * (lcm/ad)
      S_MB:    begin m_a = bn; m_b = qa; end   // bn * (lcm/bd)
      default: begin m_a = an; m_b = bn; end
    endcase
  end

  // signed sum of the scaled numerators as sign and magnitude
  always_comb begin
    if (sa == sb) begin
      sum_val = ta + tb;
      sum_neg = sa;
    end else if (ta >= tb) begin
      sum_val = ta - tb;
      sum_neg = sa;
    end else begin
      sum_val = tb - ta;
      sum_neg = sb;
    end
  end

  // reduce only looks at a_den; add and multiply need both denominators
  assign bad_den = (ad == '0) || (op != FUNC_RED && bd == '0);

  always_comb begin
    go_next   = 1'b0;
    done_next = 1'b0;
    unique case (state)
      S_PREP:                     done_next = (op == FUNC_BAD) || bad_den;
      S_GCD:                      go_next = (y != '0);
      S_LA, S_LB, S_DIVN, S_DIVD: go_next = 1'b1;
      S_CHK:                      done_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      dreq.go <= 1'b0;
    end else begin
      done    <= done_next;
      dreq.go <= go_next;
      unique case (state)
        S_IDLE: if (start) begin
          busy  <= 1'b1;
          op    <= func_t'(func);
          an    <= mag(a_num);
          ad    <= mag(a_den);
          bn    <= mag(b_num);
          bd    <= mag(b_den);
          sa    <= a_num[W-1] ^ a_den[W-1];
          sb    <= b_num[W-1] ^ b_den[W-1];
          state <= S_PREP;
        end
        S_PREP: begin
          if (op == FUNC_BAD) begin
            res_num        <= '0;
            res_den        <= (W-1)'(1);
            zero_den_error <= 1'b0;
            overflow       <= 1'b0;
            busy           <= 1'b0;
            state          <= S_IDLE;
          end else if (bad_den) begin
            res_num        <= '0;
            res_den        <= (W-1)'(1);
            zero_den_error <= 1'b1;
            overflow       <= 1'b0;
            busy           <= 1'b0;
            state          <= S_IDLE;
          end else if (op == FUNC_RED) begin
            num      <= DW'(an);
            den      <= DW'(ad);
            neg      <= sa;
            x        <= DW'(an);
            y        <= DW'(ad);
            lcm_pass <= 1'b0;
            state    <= S_GCD;
          end else if (op == FUNC_MUL) begin
            num      <= m_p;
            x        <= m_p;
            neg      <= sa ^ sb;
            lcm_pass <= 1'b0;
            state    <= S_MULD;
          end else begin
            x        <= DW'(ad);
            y        <= DW'(bd);
            lcm_pass <= 1'b1;
            state    <= S_GCD;
          end
        end
        S_MULD: begin
          den   <= m_p;
          y     <= m_p;
          state <= S_GCD;
        end
        // Euclid: x,y -> y, x mod y until y is zero
        S_GCD: begin
          if (y == '0) begin
            g <= x;
            if (lcm_pass) state <= S_LA;
            else          state <= S_DIVN;
          end else begin
            dreq.dividend <= x;
            dreq.divisor  <= y;
            state         <= S_GCDW;
          end
        end
        S_GCDW: if (drsp.done) begin
          x     <= y;
          y     <= drsp.rem;
          state <= S_GCD;
        end
        // add: qa = ad/g, qb = bd/g; lcm = qa*bd, ta = an*qb, tb = bn*qa
        S_LA: begin
          dreq.dividend <= DW'(ad);
          dreq.divisor  <= g;
          state         <= S_LAW;
        end
        S_LAW: if (drsp.done) begin
          qa    <= W'(drsp.quot);
          state <= S_LB;
        end
        S_LB: begin
          dreq.dividend <= DW'(bd);
          dreq.divisor  <= g;
          state         <= S_LBW;
        end
        S_LBW: if (drsp.done) begin
          qb    <= W'(drsp.quot);
          state <= S_ML;
        end
        S_ML: begin
          den   <= m_p;
          state <= S_MA;
        end
        S_MA: begin
          ta    <= m_p;
          state <= S_MB;
        end
        S_MB: begin
          tb    <= m_p;
          state <= S_SUM;
        end
        // second Euclid run on sum and lcm
        S_SUM: begin
          num      <= sum_val;
          x        <= sum_val;
          neg      <= sum_neg;
          y        <= den;
          lcm_pass <= 1'b0;
          state    <= S_GCD;
        end
        S_DIVN: begin
          dreq.dividend <= num;
          dreq.divisor  <= g;
          state         <= S_DIVNW;
        end
        S_DIVNW: if (drsp.done) begin
          num   <= drsp.quot;
          state <= S_DIVD;
        end
        S_DIVD: begin
          dreq.dividend <= den;
          dreq.divisor  <= g;
          state         <= S_DIVDW;
        end
        S_DIVDW: if (drsp.done) begin
          den   <= drsp.quot;
          state <= S_CHK;
        end
        // range check of the reduced value
        S_CHK: begin
          busy           <= 1'b0;
          state          <= S_IDLE;
          zero_den_error <= 1'b0;
          if (num == '0) begin
            res_num  <= '0;
            res_den  <= (W-1)'(1);
            overflow <= 1'b0;
          end else if (den > POS_MAX || num > (neg ? NEG_MAG : POS_MAX)) begin
            res_num  <= '0;
            res_den  <= (W-1)'(1);
            overflow <= 1'b1;
          end else begin
            res_num  <= neg ? W'(-num) : W'(num);
            res_den  <= den[W-2:0];
            overflow <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/rat_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on rat_pkg. Divisor must be nonzero.
module rat_div
  import rat_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic          busy;
  logic          done_r;
  logic [CW-1:0] cnt;
  logic [DW-1:0] q, d;
  logic [DW:0]   r;
  logic [DW:0]   r_sh;
  logic [DW:0]   r_sub;

  assign r_sh  = {r[DW-1:0], q[DW-1]};
  assign r_sub = r_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        q    <= req.dividend;
        d    <= req.divisor;
        r    <= '0;
      end else if (busy) begin
        if (r_sub[DW]) begin
          r <= r_sh;
          q <= {q[DW-2:0], 1'b0};
        end else begin
          r <= r_sub;
          q <= {q[DW-2:0], 1'b1};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, quot: q, rem: r[DW-1:0]};
endmodule
